[src/ccdik_pkg.sv]
package ccdik_pkg;

  localparam int JOINTS       = 3;
  localparam int CORDIC_ITERS = 16;

  // Index widths for joints (0..JOINTS-1) and points (0..JOINTS).
  localparam int AIW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int PIW = $clog2(JOINTS + 1);
  localparam int ITW = (CORDIC_ITERS > 1) ? $clog2(CORDIC_ITERS) : 1;

  // CORDIC datapath widths: vectors and angles (2^32 units per turn).
  localparam int XW = 40;
  localparam int ZW = 34;
  // Dot and cross products.
  localparam int PW = 36;
  // Shared multiplier operands and product.
  localparam int MAW = 34;
  localparam int MBW = 18;
  localparam int MPW = MAW + MBW;

  localparam int CORDIC_GAIN  = 39797;
  localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sd1073741824);

  localparam logic [11:0] RST_LINK_LENGTH = 12'd1600;
  localparam logic [15:0] RST_BASE_X      = 16'd6400;
  localparam logic [15:0] RST_BASE_Y      = 16'd4800;
  localparam logic [7:0]  RST_TOLERANCE   = 8'd2;
  localparam logic [15:0] RST_STEP_GAIN   = 16'd1311;

  typedef enum logic [2:0] {
    REG_LINK_LENGTH = 3'd0,
    REG_BASE_X      = 3'd1,
    REG_BASE_Y      = 3'd2,
    REG_TOLERANCE   = 3'd3,
    REG_STEP_GAIN   = 3'd4
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FK_INIT,
    ST_FK_ROT,
    ST_FK_WAIT,
    ST_CHK0,
    ST_CHK1,
    ST_CHK2,
    ST_J0,
    ST_J1,
    ST_J2,
    ST_J3,
    ST_J4,
    ST_J5,
    ST_J6,
    ST_J7,
    ST_J8,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic vec_mode;
  } cordic_ctl_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    case (idx)
      5'd0:  atan_entry = 32'd536870912;
      5'd1:  atan_entry = 32'd316933406;
      5'd2:  atan_entry = 32'd167458907;
      5'd3:  atan_entry = 32'd85004756;
      5'd4:  atan_entry = 32'd42667331;
      5'd5:  atan_entry = 32'd21354465;
      5'd6:  atan_entry = 32'd10679838;
      5'd7:  atan_entry = 32'd5340245;
      5'd8:  atan_entry = 32'd2670163;
      5'd9:  atan_entry = 32'd1335087;
      5'd10: atan_entry = 32'd667544;
      5'd11: atan_entry = 32'd333772;
      5'd12: atan_entry = 32'd166886;
      5'd13: atan_entry = 32'd83443;
      5'd14: atan_entry = 32'd41722;
      5'd15: atan_entry = 32'd20861;
      5'd16: atan_entry = 32'd10430;
      5'd17: atan_entry = 32'd5215;
      5'd18: atan_entry = 32'd2608;
      5'd19: atan_entry = 32'd1304;
      5'd20: atan_entry = 32'd652;
      5'd21: atan_entry = 32'd326;
      5'd22: atan_entry = 32'd163;
      5'd23: atan_entry = 32'd81;
      default: atan_entry = 32'd0;
    endcase
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    if (v > 17'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -17'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = 16'(v);
    end
  endfunction

  // Divide by 2^16, rounding half away from zero.
  function automatic logic signed [15:0] rnd16(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] t;
    if (!v[XW-1]) begin
      t = (v + XW'(32768)) >>> 16;
    end else begin
      t = -((-v + XW'(32768)) >>> 16);
    end
    rnd16 = 16'(t);
  endfunction

endpackage

[src/ccdik_mul.sv]
module ccdik_mul
  import ccdik_pkg::*;
(
  input  logic                  clk,
  input  logic signed [MAW-1:0] a_i,
  input  logic signed [MBW-1:0] b_i,
  output logic signed [MPW-1:0] p_o
);

  logic signed [MPW-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= MPW'(a_i) * MPW'(b_i);
  end

  assign p_o = p_r;

endmodule

[src/ccdik_cordic.sv]
module ccdik_cordic
  import ccdik_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cordic_ctl_t          ctl_i,
  input  logic [15:0]          ang_i,
  input  logic [11:0]          len_i,
  input  logic signed [PW-1:0] vx_i,
  input  logic signed [PW-1:0] vy_i,
  output logic                 done_o,
  output logic signed [15:0]   rx_o,
  output logic signed [15:0]   ry_o,
  output logic signed [ZW-1:0] z_o
);

  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [ITW-1:0]       it_r, it_nxt;
  logic                 vec_r, vec_nxt;
  logic                 flip_r, flip_nxt;
  logic                 zero_r, zero_nxt;
  logic signed [XW-1:0] x_r, x_nxt;
  logic signed [XW-1:0] y_r, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;

  always_comb begin
    logic [31:0]          uz;
    logic [27:0]          xl;
    logic signed [XW-1:0] sx;
    logic signed [XW-1:0] sy;
    logic signed [XW-1:0] vx;
    logic signed [XW-1:0] vy;
    logic signed [ZW-1:0] at;
    logic                 pos;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    it_nxt   = it_r;
    vec_nxt  = vec_r;
    flip_nxt = flip_r;
    zero_nxt = zero_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    uz       = {ang_i, 16'h0000};
    xl       = 28'(len_i) * 28'(CORDIC_GAIN);
    vx       = XW'(vx_i);
    vy       = XW'(vy_i);
    sx       = x_r >>> it_r;
    sy       = y_r >>> it_r;
    at       = signed'(ZW'(atan_entry(5'(it_r))));
    pos      = vec_r ? !y_r[XW-1] : !z_r[ZW-1];
    if (ctl_i.start) begin
      run_nxt  = 1'b1;
      it_nxt   = '0;
      vec_nxt  = ctl_i.vec_mode;
      zero_nxt = 1'b0;
      flip_nxt = 1'b0;
      if (ctl_i.vec_mode) begin
        zero_nxt = (vx_i == '0) && (vy_i == '0);
        if (vx[XW-1]) begin
          // Pre-rotate by a quarter turn so the vector lies in the right half.
          if (!vy[XW-1]) begin
            x_nxt = vy;
            y_nxt = -vx;
            z_nxt = QUARTER_TURN;
          end else begin
            x_nxt = -vy;
            y_nxt = vx;
            z_nxt = -QUARTER_TURN;
          end
        end else begin
          x_nxt = vx;
          y_nxt = vy;
          z_nxt = '0;
        end
      end else begin
        // Fold the angle into the half turn around zero.
        flip_nxt = (uz[31:30] == 2'b01) || (uz[31:30] == 2'b10);
        if (flip_nxt) begin
          uz[31] = ~uz[31];
        end
        z_nxt = ZW'(signed'(uz));
        x_nxt = signed'(XW'(xl));
        y_nxt = '0;
      end
    end else if (run_r) begin
      if (pos != vec_r) begin
        x_nxt = x_r - sy;
        y_nxt = y_r + sx;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + sy;
        y_nxt = y_r - sx;
        z_nxt = z_r + at;
      end
      it_nxt = it_r + 1'b1;
      if (it_r == ITW'(CORDIC_ITERS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    it_r   <= it_nxt;
    vec_r  <= vec_nxt;
    flip_r <= flip_nxt;
    zero_r <= zero_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
  end

  assign done_o = done_r;
  assign rx_o   = rnd16(flip_r ? -x_r : x_r);
  assign ry_o   = rnd16(flip_r ? -y_r : y_r);
  assign z_o    = zero_r ? '0 : z_r;

endmodule

[src/ccd_inverse_kinematics_2d.sv]
// Channel  Direction  Transaction
// in_      slave      one tick: target point
// out_     master     one link of the arm, JOINTS per tick, base first
// cfg_     write      one register write, no read-back
//
// A tick that moves the arm runs a forward kinematics pass and a tolerance check, then
// for each joint an update and another pass, and then emits the links. A tick within
// tolerance skips the joint updates. The shared CORDIC unit, one iteration per cycle,
// is run once for every link of each forward kinematics pass and once per joint for atan2.
// in_tready is high only while idle. Reset is synchronous and active low.
// A stalled output holds the sequencer until the link is taken.
module ccd_inverse_kinematics_2d
  import ccdik_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // target_x, target_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // link_index, start_x, start_y, end_x, end_y,
                                  // joint_angle_out, zero pad
  output logic        out_tuser,  // converged
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  state_t state_r, state_nxt;

  logic [11:0]        len_r, len_nxt;
  logic signed [15:0] base_x_r, base_x_nxt;
  logic signed [15:0] base_y_r, base_y_nxt;
  logic [7:0]         tol_r, tol_nxt;
  logic [15:0]        gain_r, gain_nxt;

  logic [15:0]        ang_r [JOINTS];
  logic [15:0]        ang_nxt [JOINTS];
  logic signed [15:0] px_r [JOINTS+1];
  logic signed [15:0] px_nxt [JOINTS+1];
  logic signed [15:0] py_r [JOINTS+1];
  logic signed [15:0] py_nxt [JOINTS+1];

  logic signed [15:0]   tx_r, tx_nxt, ty_r, ty_nxt;
  logic signed [15:0]   fkx_r, fkx_nxt, fky_r, fky_nxt;
  logic [15:0]          cum_r, cum_nxt;
  logic [AIW-1:0]       fi_r, fi_nxt, ji_r, ji_nxt, ek_r, ek_nxt;
  logic                 after_r, after_nxt;
  logic                 conv_r, conv_nxt;
  logic signed [PW-1:0] acc_r, acc_nxt, acc2_r, acc2_nxt;
  logic signed [16:0]   ex_r, ex_nxt, ey_r, ey_nxt, gx_r, gx_nxt, gy_r, gy_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic signed [15:0]   prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [87:0]        out_data_r, out_data_nxt;
  logic               out_conv_r, out_conv_nxt;
  logic               out_last_r, out_last_nxt;

  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [MPW-1:0] mul_p;

  cordic_ctl_t          cctl;
  logic [15:0]          c_ang;
  logic signed [PW-1:0] c_vx, c_vy;
  logic                 c_done;
  logic signed [15:0]   c_rx, c_ry;
  logic signed [ZW-1:0] c_z;

  logic [AIW-1:0]       aidx;
  logic [PIW-1:0]       pidx;
  logic [15:0]          ang_rd;
  logic signed [15:0]   rd_x, rd_y;
  logic                 fi_last, ek_last, out_free;
  logic signed [PW-1:0] tolsq;

  ccdik_mul u_mul (
    .clk (clk),
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  ccdik_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (cctl),
    .ang_i  (c_ang),
    .len_i  (len_r),
    .vx_i   (c_vx),
    .vy_i   (c_vy),
    .done_o (c_done),
    .rx_o   (c_rx),
    .ry_o   (c_ry),
    .z_o    (c_z)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign fi_last   = (fi_r == AIW'(JOINTS - 1));
  assign ek_last   = (ek_r == AIW'(JOINTS - 1));
  assign out_free  = !out_valid_r || out_tready;
  assign tolsq     = signed'(PW'(16'(tol_r) * 16'(tol_r)));

  always_comb begin
    case (state_r)
      ST_FK_ROT, ST_FK_WAIT: aidx = fi_r;
      ST_EMIT:               aidx = ek_r;
      default:               aidx = ji_r;
    endcase
    pidx   = (state_r == ST_EMIT) ? PIW'(ek_r) + 1'b1 : PIW'(ji_r);
    ang_rd = ang_r[aidx];
    rd_x   = px_r[pidx];
    rd_y   = py_r[pidx];
  end

  always_comb begin
    len_nxt    = len_r;
    base_x_nxt = base_x_r;
    base_y_nxt = base_y_r;
    tol_nxt    = tol_r;
    gain_nxt   = gain_r;
    if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_LINK_LENGTH: len_nxt    = cfg_wdata[11:0];
        REG_BASE_X:      base_x_nxt = signed'(cfg_wdata);
        REG_BASE_Y:      base_y_nxt = signed'(cfg_wdata);
        REG_TOLERANCE:   tol_nxt    = cfg_wdata[7:0];
        REG_STEP_GAIN:   gain_nxt   = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_tvalid) state_nxt = ST_FK_INIT;
      ST_FK_INIT: state_nxt = ST_FK_ROT;
      ST_FK_ROT:  state_nxt = ST_FK_WAIT;
      ST_FK_WAIT: begin
        if (c_done) begin
          if (!fi_last) begin
            state_nxt = ST_FK_ROT;
          end else if (!after_r) begin
            state_nxt = ST_CHK0;
          end else if (ji_r == '0) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_J0;
          end
        end
      end
      ST_CHK0:    state_nxt = ST_CHK1;
      ST_CHK1:    state_nxt = ST_CHK2;
      ST_CHK2:    state_nxt = ((acc_r + PW'(mul_p)) < tolsq) ? ST_EMIT : ST_J0;
      ST_J0:      state_nxt = ST_J1;
      ST_J1:      state_nxt = ST_J2;
      ST_J2:      state_nxt = ST_J3;
      ST_J3:      state_nxt = ST_J4;
      ST_J4:      state_nxt = ST_J5;
      ST_J5:      state_nxt = ST_J6;
      ST_J6:      if (c_done) state_nxt = ST_J7;
      ST_J7:      state_nxt = ST_J8;
      ST_J8:      state_nxt = ST_FK_INIT;
      ST_EMIT:    if (out_free && ek_last) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    logic signed [16:0]    d17;
    logic signed [MPW+1:0] pe;
    logic signed [MPW+1:0] rq;
    logic [PIW-1:0]        pw;
    ang_nxt       = ang_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    tx_nxt        = tx_r;
    ty_nxt        = ty_r;
    fkx_nxt       = fkx_r;
    fky_nxt       = fky_r;
    cum_nxt       = cum_r;
    fi_nxt        = fi_r;
    ji_nxt        = ji_r;
    ek_nxt        = ek_r;
    after_nxt     = after_r;
    conv_nxt      = conv_r;
    acc_nxt       = acc_r;
    acc2_nxt      = acc2_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    gx_nxt        = gx_r;
    gy_nxt        = gy_r;
    z_nxt         = z_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    out_conv_nxt  = out_conv_r;
    out_last_nxt  = out_last_r;
    mul_a         = '0;
    mul_b         = '0;
    cctl          = '0;
    c_ang         = cum_r + ang_rd;
    c_vx          = '0;
    c_vy          = '0;
    d17           = '0;
    pe            = (MPW+2)'(mul_p);
    rq            = '0;
    pw            = PIW'(fi_r) + 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          tx_nxt    = signed'(in_tdata[15:0]);
          ty_nxt    = signed'(in_tdata[31:16]);
          after_nxt = 1'b0;
        end
      end
      ST_FK_INIT: begin
        fkx_nxt   = base_x_r;
        fky_nxt   = base_y_r;
        px_nxt[0] = base_x_r;
        py_nxt[0] = base_y_r;
        cum_nxt   = '0;
        fi_nxt    = '0;
      end
      ST_FK_ROT: begin
        cum_nxt    = cum_r + ang_rd;
        cctl.start = 1'b1;
      end
      ST_FK_WAIT: begin
        if (c_done) begin
          fkx_nxt    = sat16(17'(fkx_r) + 17'(c_rx));
          fky_nxt    = sat16(17'(fky_r) + 17'(c_ry));
          px_nxt[pw] = fkx_nxt;
          py_nxt[pw] = fky_nxt;
          fi_nxt     = fi_r + 1'b1;
          if (fi_last) begin
            ek_nxt = '0;
            if (after_r && (ji_r != '0)) begin
              ji_nxt = ji_r - 1'b1;
            end
          end
        end
      end
      ST_CHK0: begin
        d17   = 17'(tx_r) - 17'(px_r[JOINTS]);
        mul_a = MAW'(d17);
        mul_b = MBW'(d17);
      end
      ST_CHK1: begin
        acc_nxt = PW'(mul_p);
        d17     = 17'(ty_r) - 17'(py_r[JOINTS]);
        mul_a   = MAW'(d17);
        mul_b   = MBW'(d17);
      end
      ST_CHK2: begin
        conv_nxt = (acc_r + PW'(mul_p)) < tolsq;
        ek_nxt   = '0;
        ji_nxt   = AIW'(JOINTS - 1);
      end
      ST_J0: begin
        ex_nxt = 17'(px_r[JOINTS]) - 17'(rd_x);
        ey_nxt = 17'(py_r[JOINTS]) - 17'(rd_y);
        gx_nxt = 17'(tx_r) - 17'(rd_x);
        gy_nxt = 17'(ty_r) - 17'(rd_y);
      end
      ST_J1: begin
        mul_a = MAW'(ex_r);
        mul_b = MBW'(gy_r);
      end
      ST_J2: begin
        acc_nxt = PW'(mul_p);
        mul_a   = MAW'(ey_r);
        mul_b   = MBW'(gx_r);
      end
      ST_J3: begin
        // Cross product of joint-to-end against joint-to-target.
        acc_nxt = acc_r - PW'(mul_p);
        mul_a   = MAW'(ex_r);
        mul_b   = MBW'(gx_r);
      end
      ST_J4: begin
        acc2_nxt = PW'(mul_p);
        mul_a    = MAW'(ey_r);
        mul_b    = MBW'(gy_r);
      end
      ST_J5: begin
        cctl.start    = 1'b1;
        cctl.vec_mode = 1'b1;
        c_vx          = acc2_r + PW'(mul_p);
        c_vy          = acc_r;
      end
      ST_J6: begin
        if (c_done) begin
          z_nxt = c_z;
        end
      end
      ST_J7: begin
        mul_a = z_r;
        mul_b = signed'({2'b00, gain_r});
      end
      ST_J8: begin
        // Scale by 2^-32, rounding half away from zero.
        if (!pe[MPW+1]) begin
          rq = (pe + (MPW+2)'(64'd2147483648)) >>> 32;
        end else begin
          rq = -((-pe + (MPW+2)'(64'd2147483648)) >>> 32);
        end
        ang_nxt[ji_r] = ang_rd + rq[15:0];
        after_nxt     = 1'b1;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'b00000, ang_rd, rd_y, rd_x,
                           (ek_r == '0) ? py_r[0] : prev_y_r,
                           (ek_r == '0) ? px_r[0] : prev_x_r,
                           3'(ek_r)};
          out_conv_nxt  = conv_r;
          out_last_nxt  = ek_last;
          prev_x_nxt    = rd_x;
          prev_y_nxt    = rd_y;
          ek_nxt        = ek_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      len_r       <= RST_LINK_LENGTH;
      base_x_r    <= signed'(RST_BASE_X);
      base_y_r    <= signed'(RST_BASE_Y);
      tol_r       <= RST_TOLERANCE;
      gain_r      <= RST_STEP_GAIN;
      for (int i = 0; i < JOINTS; i++) begin
        ang_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      len_r       <= len_nxt;
      base_x_r    <= base_x_nxt;
      base_y_r    <= base_y_nxt;
      tol_r       <= tol_nxt;
      gain_r      <= gain_nxt;
      ang_r       <= ang_nxt;
    end
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    tx_r       <= tx_nxt;
    ty_r       <= ty_nxt;
    fkx_r      <= fkx_nxt;
    fky_r      <= fky_nxt;
    cum_r      <= cum_nxt;
    fi_r       <= fi_nxt;
    ji_r       <= ji_nxt;
    ek_r       <= ek_nxt;
    after_r    <= after_nxt;
    conv_r     <= conv_nxt;
    acc_r      <= acc_nxt;
    acc2_r     <= acc2_nxt;
    ex_r       <= ex_nxt;
    ey_r       <= ey_nxt;
    gx_r       <= gx_nxt;
    gy_r       <= gy_nxt;
    z_r        <= z_nxt;
    prev_x_r   <= prev_x_nxt;
    prev_y_r   <= prev_y_nxt;
    out_data_r <= out_data_nxt;
    out_conv_r <= out_conv_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_conv_r;
  assign out_tlast  = out_last_r;

endmodule

[src/ccdik_checker.sv]
module ccdik_checker
  import ccdik_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata,
  input logic        out_tlast
);

  // The block works on one tick at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a tick is in progress");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)
                                     && $stable(out_tlast)))
    else $error("stalled output changed");

  a_last_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[2:0] == 3'(JOINTS - 1))))
    else $error("tlast does not mark the final link");

  // No new tick is taken while links of the current tick are still to come.
  a_no_accept_mid_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> !in_tready)
    else $error("input ready in the middle of a tick's links");

endmodule

bind ccd_inverse_kinematics_2d ccdik_checker u_ccdik_checker (.*);
